/* hw/rtl/dqvs_pkg.sv */
// ----------------------------------------------------------------------------
// dqvs_pkg
// Shared sizes, codes, result type and slot arithmetic for the deque block.
// ----------------------------------------------------------------------------
package dqvs_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OUT_W      = 32;
    localparam int VAL_IN_W   = 32;

    // action codes
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_CONTAINS   = 3'd4;
    localparam logic [2:0] ACT_REMOVE     = 3'd5;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef struct packed {
        logic [1:0]             status;
        logic                   found;
        cnt_t                   entry_count;
        logic                   is_empty;
        logic signed [OUT_W-1:0] front_value;
        logic signed [OUT_W-1:0] back_value;
    } result_t;

    // physical slot of logical position pos, counted from head
    function automatic addr_t slot_of(input addr_t head, input cnt_t pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
        if (sum >= (CNT_W+1)'(DEPTH)) begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // keep the low WORD_WIDTH bits of the input word
    function automatic word_t to_word(input logic [VAL_IN_W-1:0] v);
        word_t w;
        for (int i = 0; i < WORD_WIDTH; i++) begin
            w[i] = (i < VAL_IN_W) ? v[i] : v[VAL_IN_W-1];
        end
        return w;
    endfunction

    // sign-extend a stored word to the result width
    function automatic logic [OUT_W-1:0] to_out(input word_t w);
        logic [OUT_W-1:0] r;
        for (int i = 0; i < OUT_W; i++) begin
            r[i] = (i < WORD_WIDTH) ? w[i] : w[WORD_WIDTH-1];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/dqvs_ram.sv */
// ----------------------------------------------------------------------------
// dqvs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dqvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/dqvs_ctrl.sv */
// ----------------------------------------------------------------------------
// dqvs_ctrl
// Operation sequencer: pointer updates, scan, gap closing, front/back fetch.
// ----------------------------------------------------------------------------
module dqvs_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               in_action,
    input  dqvs_pkg::word_t          in_value,
    output logic                     res_valid,
    input  logic                     res_ready,
    output dqvs_pkg::result_t        res,
    output logic                     mem_we,
    output dqvs_pkg::addr_t          mem_waddr,
    output dqvs_pkg::word_t          mem_wdata,
    output logic                     mem_re,
    output dqvs_pkg::addr_t          mem_raddr,
    input  dqvs_pkg::word_t          mem_rdata
);

    import dqvs_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SHIFT    = 3'd3;
    localparam logic [2:0] S_RD_FRONT = 3'd4;
    localparam logic [2:0] S_RD_BACK  = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    localparam cnt_t CNT_FULL = CNT_W'(DEPTH);
    localparam cnt_t CNT_ONE  = CNT_W'(1);

    logic [2:0] state_reg, state_next;
    addr_t      head_reg, head_next;
    cnt_t       count_reg, count_next;
    logic [2:0] act_reg, act_next;
    word_t      val_reg, val_next;
    logic [1:0] status_reg, status_next;
    logic       found_reg, found_next;
    cnt_t       iss_reg, iss_next;
    logic       pend_reg, pend_next;
    cnt_t       ppos_reg, ppos_next;
    word_t      front_reg, front_next;

    addr_t      head_dec;
    logic       match;
    logic       empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        iss_reg    <= iss_next;
        ppos_reg   <= ppos_next;
        front_reg  <= front_next;
    end

    assign head_dec = (head_reg == '0) ? addr_t'(DEPTH - 1) : head_reg - addr_t'(1);
    assign match    = pend_reg && (mem_rdata == val_reg);
    assign empty    = (count_reg == '0);

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        act_next    = act_reg;
        val_next    = val_reg;
        status_next = status_reg;
        found_next  = found_reg;
        iss_next    = iss_reg;
        pend_next   = pend_reg;
        ppos_next   = ppos_reg;
        front_next  = front_reg;
        mem_we      = 1'b0;
        mem_waddr   = head_reg;
        mem_wdata   = val_reg;
        mem_re      = 1'b0;
        mem_raddr   = head_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    act_next    = in_action;
                    val_next    = in_value;
                    status_next = STAT_OK;
                    found_next  = 1'b0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RD_FRONT;
                unique case (act_reg)
                    ACT_PUSH_FRONT: begin
                        if (count_reg == CNT_FULL) begin
                            status_next = STAT_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            mem_waddr  = head_dec;
                            head_next  = head_dec;
                            count_next = count_reg + CNT_ONE;
                        end
                    end
                    ACT_PUSH_BACK: begin
                        if (count_reg == CNT_FULL) begin
                            status_next = STAT_FULL;
                        end else begin
                            mem_we     = 1'b1;
                            mem_waddr  = slot_of(head_reg, count_reg);
                            count_next = count_reg + CNT_ONE;
                        end
                    end
                    ACT_POP_FRONT: begin
                        if (empty) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            head_next  = slot_of(head_reg, CNT_ONE);
                            count_next = count_reg - CNT_ONE;
                        end
                    end
                    ACT_POP_BACK: begin
                        if (empty) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            count_next = count_reg - CNT_ONE;
                        end
                    end
                    ACT_CONTAINS, ACT_REMOVE: begin
                        if (empty) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            iss_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // one read issued per cycle, compared in the following cycle
                priority if (match) begin
                    found_next = 1'b1;
                    if (act_reg == ACT_REMOVE) begin
                        iss_next   = ppos_reg + CNT_ONE;
                        pend_next  = 1'b0;
                        state_next = S_SHIFT;
                    end else begin
                        pend_next  = 1'b0;
                        state_next = S_RD_FRONT;
                    end
                end else if (pend_reg && (ppos_reg == count_reg - CNT_ONE)) begin
                    status_next = STAT_NOT_FOUND;
                    pend_next   = 1'b0;
                    state_next  = S_RD_FRONT;
                end else if (iss_reg < count_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = slot_of(head_reg, iss_reg);
                    iss_next  = iss_reg + CNT_ONE;
                    pend_next = 1'b1;
                    ppos_next = iss_reg;
                end else begin
                    pend_next = 1'b0;
                end
            end
            S_SHIFT: begin
                // write back the entry read last cycle one place nearer the front
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = slot_of(head_reg, ppos_reg);
                    mem_wdata = mem_rdata;
                end
                if (iss_reg < count_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = slot_of(head_reg, iss_reg);
                    pend_next = 1'b1;
                    ppos_next = iss_reg - CNT_ONE;
                    iss_next  = iss_reg + CNT_ONE;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        count_next = count_reg - CNT_ONE;
                        state_next = S_RD_FRONT;
                    end
                end
            end
            S_RD_FRONT: begin
                mem_re     = !empty;
                mem_raddr  = head_reg;
                state_next = S_RD_BACK;
            end
            S_RD_BACK: begin
                front_next = mem_rdata;
                mem_re     = !empty;
                mem_raddr  = slot_of(head_reg, count_reg - CNT_ONE);
                state_next = S_DONE;
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res.status      = status_reg;
        res.found       = found_reg;
        res.entry_count = count_reg;
        res.is_empty    = empty;
        res.front_value = empty ? '0 : to_out(front_reg);
        res.back_value  = empty ? '0 : to_out(mem_rdata);
    end

endmodule

/* hw/rtl/deque_with_value_search_remove_top.sv */
// ----------------------------------------------------------------------------
// deque_with_value_search_remove_top
// Bounded double-ended queue of signed words with search and remove by value.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready: s_tuser carries the action
//   (push front, push back, pop front, pop back, contains, remove value),
//   s_tdata the value. Each input word yields exactly one result word on
//   m_tvalid/m_tready: s_tuser-style status in m_tuser, and found flag,
//   entry count, empty flag, front and back values in m_tdata.
//   One item is worked at a time. For remove, scan and gap closing together
//   touch each held entry once. The slot memory has a single read port: one
//   entry is read per cycle during scan and shift, and front and back are
//   fetched one after the other.
//   Reset clears the head pointer and the entry count; slot contents are
//   not cleared, since only held entries are ever read.
//   A finished result sits in the output register; the sequencer takes the
//   next word while it waits and stalls only when a second result is ready
//   and m_tready is still low.
// ----------------------------------------------------------------------------
module deque_with_value_search_remove_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [0] found, [5:1] entry_count, [6] is_empty,
                                   // [38:7] front_value, [70:39] back_value, [71] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    import dqvs_pkg::*;

    logic     mem_we;
    addr_t    mem_waddr;
    word_t    mem_wdata;
    logic     mem_re;
    addr_t    mem_raddr;
    word_t    mem_rdata;

    logic     res_valid;
    logic     res_ready;
    result_t  res;

    logic     out_valid_reg, out_valid_next;
    result_t  out_reg, out_next;

    // slot storage
    dqvs_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // operation sequencer
    dqvs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_value  (to_word(s_tdata)),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // output register: load when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready) begin
            out_valid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    // pack the result word
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {1'b0,
                       out_reg.back_value,
                       out_reg.front_value,
                       out_reg.is_empty,
                       out_reg.entry_count,
                       out_reg.found};

endmodule

/* verif/deque_with_value_search_remove_top_tb.sv */
// ----------------------------------------------------------------------------
// deque_with_value_search_remove_top_tb
// Self-checking stream bench for the bounded deque with search and remove by
// value. A behavioral deque next to the block predicts every result word.
// Each returned word is compared field by field against the oldest
// prediction. Stimulus is a directed pass over the corner cases, then random
// walks that fill and drain the store under three idling patterns, plus one
// long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module deque_with_value_search_remove_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dqvs_pkg::*;

    // action codes the block ignores
    localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
    localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

    localparam int HOLD_CYCLES  = 400;     // length of the receiver hold-off
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
    localparam int CYCLE_LIMIT  = 600000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value
    logic [2:0]  s_tuser  = '0;   // [2:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // [0] found, [5:1] entry_count, [6] is_empty,
                                  // [38:7] front_value, [70:39] back_value, [71] zero
    logic [1:0]  m_tuser;         // [1:0] status

    // idle percentages for each side, changed between phases
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // bump to start one receiver hold-off
    int hold_token = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    int unsigned cycle_count = 0;
    int err_count   = 0;
    int n_checked   = 0;
    int n_found     = 0;
    int n_full      = 0;
    int n_empty     = 0;
    int n_not_found = 0;

    // behavioral copy of the deque
    word_t ring [DEPTH];
    int    ring_head  = 0;
    int    ring_count = 0;

    result_t pending_results [$];

    deque_with_value_search_remove_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Deque prediction: apply one action to the copy, return the result word
    // ------------------------------------------------------------------------
    function automatic result_t apply_deque_op(input logic [2:0] act, input word_t val);
        result_t r;
        int      pos;
        int      k;
        r        = '0;
        r.status = STAT_OK;
        case (act)
            ACT_PUSH_FRONT: begin
                if (ring_count == DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    ring_head       = (ring_head + DEPTH - 1) % DEPTH;
                    ring[ring_head] = val;
                    ring_count++;
                end
            end
            ACT_PUSH_BACK: begin
                if (ring_count == DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    ring[(ring_head + ring_count) % DEPTH] = val;
                    ring_count++;
                end
            end
            ACT_POP_FRONT: begin
                if (ring_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_count--;
                end
            end
            ACT_POP_BACK: begin
                if (ring_count == 0) r.status = STAT_EMPTY;
                else ring_count--;
            end
            ACT_CONTAINS, ACT_REMOVE: begin
                if (ring_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    // first match counted from the front
                    pos = ring_count;
                    for (k = ring_count - 1; k >= 0; k--) begin
                        if (ring[(ring_head + k) % DEPTH] == val) pos = k;
                    end
                    if (pos == ring_count) begin
                        r.status = STAT_NOT_FOUND;
                    end else begin
                        r.found = 1'b1;
                        if (act == ACT_REMOVE) begin
                            // close the gap toward the front
                            for (k = pos; k + 1 < ring_count; k++) begin
                                ring[(ring_head + k) % DEPTH] =
                                    ring[(ring_head + k + 1) % DEPTH];
                            end
                            ring_count--;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = cnt_t'(ring_count);
        r.is_empty    = (ring_count == 0);
        if (ring_count != 0) begin
            r.front_value = ring[ring_head];
            r.back_value  = ring[(ring_head + ring_count - 1) % DEPTH];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: idle at random, offer one word, hold it until accepted
    // ------------------------------------------------------------------------
    task automatic send_op(input logic [2:0] act, input word_t val);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_deque_op(act, val));
    endtask

    // drop valid and wait for every predicted word to come back
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, or a long hold-off when requested
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_seen = hold_token;
            hold_left = 0;
        end else if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result check: compare each accepted word with the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns  %s mismatch: expected %0h, actual %0h",
                     $time, fname, want, got);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns  result word with no prediction waiting: tuser %0h tdata %0h",
                         $time, m_tuser, m_tdata);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                case (want.status)
                    STAT_FULL:      n_full++;
                    STAT_EMPTY:     n_empty++;
                    STAT_NOT_FOUND: n_not_found++;
                    default:        if (want.found) n_found++;
                endcase
                check_field("status",      32'(want.status),      32'(m_tuser));
                check_field("found",       32'(want.found),       32'(m_tdata[0]));
                check_field("entry_count", 32'(want.entry_count), 32'(m_tdata[5:1]));
                check_field("is_empty",    32'(want.is_empty),    32'(m_tdata[6]));
                check_field("front_value", want.front_value,      m_tdata[38:7]);
                check_field("back_value",  want.back_value,       m_tdata[70:39]);
                check_field("tdata pad",   32'd0,                 32'(m_tdata[71]));
            end
        end
    end

    // hard stop if the run hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("deque_with_value_search_remove_top_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // random word: small pool for duplicates, the extremes, or anything
    function automatic word_t random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return word_t'($urandom_range(7));
        if (pick < 50) begin
            case ($urandom_range(3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return word_t'($urandom);
    endfunction

    // search key: mostly a word held right now so that matches are common
    function automatic word_t search_word();
        if (ring_count != 0 && $urandom_range(99) < 65)
            return ring[(ring_head + $urandom_range(ring_count - 1)) % DEPTH];
        return random_word();
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // pops, searches and an unused code on an empty store after reset
    task automatic test_empty_store();
        send_op(ACT_POP_FRONT, 32'h1234_5678);
        send_op(ACT_POP_BACK,  32'hFFFF_FFFF);
        send_op(ACT_CONTAINS,  32'h0000_0000);
        send_op(ACT_REMOVE,    32'h8000_0000);
        send_op(ACT_UNUSED_6,  32'h7FFF_FFFF);
    endtask

    // value extremes at both ends, hit and miss for contains and remove
    task automatic test_search_and_extremes();
        send_op(ACT_PUSH_BACK,  32'h7FFF_FFFF);
        send_op(ACT_PUSH_FRONT, 32'h8000_0000);
        send_op(ACT_PUSH_BACK,  32'h0000_0000);
        send_op(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(ACT_CONTAINS,   32'h7FFF_FFFF);
        send_op(ACT_CONTAINS,   32'h0000_0005);
        send_op(ACT_REMOVE,     32'h7FFF_FFFF);   // middle entry, gap closes
        send_op(ACT_REMOVE,     32'h0000_0123);   // absent
        send_op(ACT_UNUSED_7,   32'hA5A5_A5A5);   // report only
    endtask

    // fill with duplicates, push into a full store, remove first duplicate
    task automatic test_full_store();
        int n;
        n = 0;
        while (ring_count < DEPTH) begin
            send_op(n[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK, 32'h55 + 32'(n % 3));
            n++;
        end
        send_op(ACT_PUSH_FRONT, 32'hDEAD_BEEF);
        send_op(ACT_PUSH_BACK,  32'hDEAD_BEEF);
        send_op(ACT_REMOVE,     32'h0000_0056);
    endtask

    // random walk that alternates between filling and draining the store
    task automatic test_random_mix(input int n_items);
        logic [2:0] act;
        int         pick;
        bit         filling;
        filling = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (i % 48 == 47) filling = !filling;
            pick = $urandom_range(99);
            if (filling) begin
                if      (pick < 25) act = ACT_PUSH_FRONT;
                else if (pick < 55) act = ACT_PUSH_BACK;
                else if (pick < 63) act = ACT_POP_FRONT;
                else if (pick < 70) act = ACT_POP_BACK;
                else if (pick < 83) act = ACT_CONTAINS;
                else if (pick < 97) act = ACT_REMOVE;
                else                act = pick[0] ? ACT_UNUSED_7 : ACT_UNUSED_6;
            end else begin
                if      (pick < 10) act = ACT_PUSH_FRONT;
                else if (pick < 20) act = ACT_PUSH_BACK;
                else if (pick < 40) act = ACT_POP_FRONT;
                else if (pick < 60) act = ACT_POP_BACK;
                else if (pick < 75) act = ACT_CONTAINS;
                else if (pick < 97) act = ACT_REMOVE;
                else                act = pick[0] ? ACT_UNUSED_7 : ACT_UNUSED_6;
            end
            if (act == ACT_CONTAINS || act == ACT_REMOVE) send_op(act, search_word());
            else send_op(act, random_word());
        end
    endtask

    // hold the receiver off while the sender keeps offering words
    task automatic test_backpressure();
        hold_token <= hold_token + 1;
        for (int i = 0; i < 24; i++) begin
            send_op(i[0] ? ACT_CONTAINS : ACT_PUSH_BACK, i[0] ? search_word() : random_word());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles rarely, receiver stalls often
        tx_idle_pct <= 17;
        rx_idle_pct <= 85;
        test_empty_store();
        test_search_and_extremes();
        test_full_store();
        test_random_mix(400);

        // the other way round
        tx_idle_pct <= 85;
        rx_idle_pct <= 17;
        test_random_mix(400);

        // no idling on either side
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        test_backpressure();
        test_random_mix(400);

        drain_stream();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("checked %0d result words: %0d matches found, %0d full rejects,",
                 n_checked, n_found, n_full);
        $display("%0d empty-store results, %0d misses, one %0d-cycle receiver hold-off",
                 n_empty, n_not_found, HOLD_CYCLES);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("deque_with_value_search_remove_top_tb OK");
        end else begin
            $display("deque_with_value_search_remove_top_tb NOT OK");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/dqvs_pkg.sv
hw/rtl/dqvs_ram.sv
hw/rtl/dqvs_ctrl.sv
hw/rtl/deque_with_value_search_remove_top.sv
verif/deque_with_value_search_remove_top_tb.sv
